// File: design/tcsn_pkg.sv
// Shared types and constants for the tick count to seconds and nanoseconds converter.
package tcsn_pkg;

  localparam int unsigned NumW  = 30;
  localparam int unsigned DenW  = 32;
  localparam int unsigned TickW = 63;
  localparam int unsigned SecW  = 35;
  localparam int unsigned NsecW = 31;
  localparam int unsigned ProdW = TickW + NumW;
  localparam int unsigned TotW  = 64;

  localparam logic [NumW-1:0] NsPerSec   = 30'd1000000000;
  localparam logic [NumW-1:0] ResetNumer = 30'd100;
  localparam logic [DenW-1:0] ResetDenom = 32'd1;
  localparam logic [31:0]     InvFive    = 32'hCCCCCCCD;
  localparam logic [31:0]     MaxFifth   = 32'h33333333;

  typedef struct packed {
    logic [NumW-1:0] numer;
    logic [DenW-1:0] denom;
  } ratio_t;

endpackage

// File: design/tcsn_cell.sv
// One restoring division cell: shifts in one dividend bit and produces one quotient bit.
module tcsn_cell #(
  parameter int unsigned RW = 32,
  parameter int unsigned WW = 93
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [RW-1:0] rem_i,
  input  logic [WW-1:0] word_i,
  input  logic [RW-1:0] divisor_i,
  output logic          valid_o,
  output logic [RW-1:0] rem_o,
  output logic [WW-1:0] word_o
);
  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          ge;
  logic          valid_q;
  logic [RW-1:0] rem_q, rem_d;
  logic [WW-1:0] word_q, word_d;

  always_comb begin
    trial  = {rem_i, word_i[WW-1]};
    diff   = trial - {1'b0, divisor_i};
    ge     = trial >= {1'b0, divisor_i};
    rem_d  = ge ? diff[RW-1:0] : trial[RW-1:0];
    word_d = {word_i[WW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign word_o  = word_q;
endmodule

// File: design/tcsn_div_chain.sv
// Row of division cells that yields one quotient bit per cell.
module tcsn_div_chain #(
  parameter int unsigned RW = 32,
  parameter int unsigned WW = 93
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [WW-1:0] word_i,
  input  logic [RW-1:0] divisor_i,
  output logic          valid_o,
  output logic [WW-1:0] quot_o,
  output logic [RW-1:0] rem_o
);
  logic          v [0:WW];
  logic [RW-1:0] r [0:WW];
  logic [WW-1:0] w [0:WW];

  assign v[0] = valid_i;
  assign r[0] = '0;
  assign w[0] = word_i;

  for (genvar i = 0; i < WW; i++) begin : g_cell
    tcsn_cell #(.RW(RW), .WW(WW)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (v[i]),
      .rem_i    (r[i]),
      .word_i   (w[i]),
      .divisor_i(divisor_i),
      .valid_o  (v[i+1]),
      .rem_o    (r[i+1]),
      .word_o   (w[i+1])
    );
  end

  assign valid_o = v[WW];
  assign quot_o  = w[WW];
  assign rem_o   = r[WW];
endmodule

// File: design/tcsn_ratio.sv
// Reduces one billion and the counter frequency by their common factors of two and five.
module tcsn_ratio (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [31:0]           wdata_i,
  output tcsn_pkg::ratio_t      ratio_o,
  output logic                  busy_o
);
  import tcsn_pkg::*;

  typedef enum logic {StIdle, StRun} state_e;

  state_e          state_q;
  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic [63:0]     den_prod;
  logic [63:0]     num_prod;
  logic            both_even;
  logic            both_five;

  always_comb begin
    den_prod  = den_q * InvFive;
    num_prod  = {2'b00, num_q} * InvFive;
    both_even = !num_q[0] && !den_q[0];
    both_five = (den_prod[31:0] <= MaxFifth) && (num_prod[31:0] <= MaxFifth);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      num_q   <= ResetNumer;
      den_q   <= ResetDenom;
    end else if (we_i && (wdata_i != '0)) begin
      num_q   <= NsPerSec;
      den_q   <= wdata_i;
      state_q <= StRun;
    end else begin
      unique case (state_q)
        StIdle: begin
          state_q <= StIdle;
        end
        StRun: begin
          priority if (both_even) begin
            num_q <= num_q >> 1;
            den_q <= den_q >> 1;
          end else if (both_five) begin
            num_q <= num_prod[NumW-1:0];
            den_q <= den_prod[31:0];
          end else begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign ratio_o = '{numer: num_q, denom: den_q};
  assign busy_o  = (state_q == StRun);
endmodule

// File: design/tick_count_to_seconds_nanoseconds.sv
// Top level of the tick count to seconds and nanoseconds converter.
// A beat is taken on every cycle with start high and busy low, and its result reaches done_o
// through two multiply stages, a row of 93 cells dividing by the reduced frequency, a sign
// stage, a row of 64 cells dividing by one billion, and an output register.
// Writing a nonzero frequency holds busy high while the ratio is reduced. Results cannot
// be stalled.
module tick_count_to_seconds_nanoseconds (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [tcsn_pkg::TickW-1:0] tick_count_i,
  input  logic                      counter_frequency_we_i,
  input  logic [31:0]               counter_frequency_i,
  output logic                      done_o,
  output logic signed [tcsn_pkg::SecW-1:0]  elapsed_seconds_o,
  output logic signed [tcsn_pkg::NsecW-1:0] elapsed_nanoseconds_o
);
  import tcsn_pkg::*;

  ratio_t          ratio;
  logic            accept;
  logic            m1_valid_q, m2_valid_q, s_valid_q, out_valid_q;
  logic [61:0]     plo_q;
  logic [60:0]     phi_q;
  logic [ProdW-1:0] prod_q, prod_d;
  logic            c1_valid;
  logic [ProdW-1:0] c1_quot;
  logic [DenW-1:0] c1_rem;
  logic [TotW-1:0] total;
  logic [TotW-1:0] mag_q;
  logic [TotW:0]   neg_pipe_q;
  logic            c2_valid;
  logic [TotW-1:0] c2_quot;
  logic [NumW-1:0] c2_rem;
  logic            neg_out;
  logic [SecW-1:0] sec_mag;
  logic [NsecW-1:0] nsec_mag;
  logic [SecW-1:0] sec_q;
  logic [NsecW-1:0] nsec_q;

  tcsn_ratio u_ratio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (counter_frequency_we_i),
    .wdata_i(counter_frequency_i),
    .ratio_o(ratio),
    .busy_o (busy)
  );

  assign accept = start && !busy;
  assign prod_d = {phi_q, 32'd0} + {31'd0, plo_q};
  assign total  = c1_quot[TotW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q  <= 1'b0;
      m2_valid_q  <= 1'b0;
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      m1_valid_q  <= accept;
      m2_valid_q  <= m1_valid_q;
      s_valid_q   <= c1_valid;
      out_valid_q <= c2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    plo_q      <= tick_count_i[31:0] * ratio.numer;
    phi_q      <= tick_count_i[62:32] * ratio.numer;
    prod_q     <= prod_d;
    mag_q      <= total[TotW-1] ? (~total + 64'd1) : total;
    neg_pipe_q <= {neg_pipe_q[TotW-1:0], total[TotW-1]};
  end

  tcsn_div_chain #(.RW(DenW), .WW(ProdW)) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (m2_valid_q),
    .word_i   (prod_q),
    .divisor_i(ratio.denom),
    .valid_o  (c1_valid),
    .quot_o   (c1_quot),
    .rem_o    (c1_rem)
  );

  tcsn_div_chain #(.RW(NumW), .WW(TotW)) u_split (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_valid_q),
    .word_i   (mag_q),
    .divisor_i(NsPerSec),
    .valid_o  (c2_valid),
    .quot_o   (c2_quot),
    .rem_o    (c2_rem)
  );

  always_comb begin
    neg_out  = neg_pipe_q[TotW];
    sec_mag  = c2_quot[SecW-1:0];
    nsec_mag = {1'b0, c2_rem};
  end

  always_ff @(posedge clk_i) begin
    sec_q  <= neg_out ? (~sec_mag + 35'd1) : sec_mag;
    nsec_q <= neg_out ? (~nsec_mag + 31'd1) : nsec_mag;
  end

  assign done_o                = out_valid_q;
  assign elapsed_seconds_o     = sec_q;
  assign elapsed_nanoseconds_o = nsec_q;

  logic unused_rem;
  assign unused_rem = ^c1_rem;
endmodule

// File: tb/tick_count_to_seconds_nanoseconds_tb.sv
// Testbench that checks tick count conversion against a local model over several frequencies.
module tick_count_to_seconds_nanoseconds_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcsn_pkg::*;

  localparam logic [31:0] ResetFreq = 32'd10000000;
  localparam int unsigned WatchLimit = 3000;

  typedef struct {
    logic signed [SecW-1:0]  secs;
    logic signed [NsecW-1:0] nsecs;
  } elapsed_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [TickW-1:0] tick_count_i = '0;
  logic counter_frequency_we_i = 1'b0;
  logic [31:0] counter_frequency_i = '0;
  logic done_o;
  logic signed [SecW-1:0] elapsed_seconds_o;
  logic signed [NsecW-1:0] elapsed_nanoseconds_o;

  elapsed_t due_q[$];
  logic [63:0] ratio_num, ratio_den;
  int unsigned errors = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_seen = 0;
  int unsigned freq_writes = 0;
  int unsigned idle_cycles = 0;

  tick_count_to_seconds_nanoseconds dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .tick_count_i(tick_count_i),
    .counter_frequency_we_i(counter_frequency_we_i),
    .counter_frequency_i(counter_frequency_i),
    .done_o(done_o),
    .elapsed_seconds_o(elapsed_seconds_o),
    .elapsed_nanoseconds_o(elapsed_nanoseconds_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void reduce_ratio(input logic [31:0] freq);
    logic [63:0] a, b, t;
    a = {32'd0, freq};
    b = 64'd1000000000;
    while (b != 0) begin
      t = b;
      b = a % b;
      a = t;
    end
    ratio_num = 64'd1000000000 / a;
    ratio_den = {32'd0, freq} / a;
  endfunction

  function automatic elapsed_t convert_ticks(input logic [TickW-1:0] ticks);
    logic [127:0] prod;
    logic [63:0] total;
    logic signed [63:0] stot, sq, sr;
    elapsed_t r;
    prod = {65'd0, ticks} * {64'd0, ratio_num};
    prod = prod / {64'd0, ratio_den};
    total = prod[63:0];
    stot = total;
    sq = stot / 64'sd1000000000;
    sr = stot % 64'sd1000000000;
    r.secs = sq[SecW-1:0];
    r.nsecs = sr[NsecW-1:0];
    return r;
  endfunction

  task automatic send_ticks(input logic [TickW-1:0] ticks);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    tick_count_i <= ticks;
    do @(posedge clk_i); while (busy);
    due_q.push_back(convert_ticks(ticks));
    beats_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_freq(input logic [31:0] freq);
    drain();
    counter_frequency_we_i <= 1'b1;
    counter_frequency_i <= freq;
    @(posedge clk_i);
    counter_frequency_we_i <= 1'b0;
    if (freq != 0) reduce_ratio(freq);
    freq_writes++;
    @(posedge clk_i);
  endtask

  function automatic logic [TickW-1:0] rand_ticks();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: w = w >> $urandom_range(1, 62);
      1: w = 64'h7FFF_FFFF_FFFF_FFFF - (w >> 40);
      default: ;
    endcase
    return w[TickW-1:0];
  endfunction

  task automatic test_default_ratio();
    send_ticks('0);
    send_ticks(63'd1);
    send_ticks(63'd9999999);
    send_ticks(63'd10000000);
    send_ticks(63'd92233720368547758);
    send_ticks(63'd92233720368547759);
    send_ticks({TickW{1'b1}});
    send_ticks(63'h5555_5555_5555_5555);
    send_ticks(63'h2AAA_AAAA_AAAA_AAAA);
  endtask

  task automatic test_freq_extremes();
    write_freq(32'd1);
    send_ticks(63'd1);
    send_ticks(63'd9223372036);
    send_ticks({TickW{1'b1}});
    write_freq(32'd1000000000);
    send_ticks(63'd999999999);
    send_ticks({TickW{1'b1}});
    write_freq(32'hFFFF_FFFF);
    send_ticks(63'd858993459);
    send_ticks({TickW{1'b1}});
    send_ticks(63'h0000_0000_FFFF_FFFF);
    write_freq(32'd0);
    send_ticks({TickW{1'b1}});
    write_freq(32'd3);
    send_ticks(63'd2);
    send_ticks({TickW{1'b1}});
  endtask

  task automatic test_random_phase(input logic [31:0] freq, input int count);
    write_freq(freq);
    repeat (count) send_ticks(rand_ticks());
  endtask

  task automatic test_full_pause();
    repeat (20) send_ticks(rand_ticks());
    drain();
    repeat (40) send_ticks(rand_ticks());
  endtask

  always @(posedge clk_i) begin
    if (done_o) begin
      beats_seen++;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result sec=%0d nsec=%0d", $time,
                 elapsed_seconds_o, elapsed_nanoseconds_o);
      end else begin
        elapsed_t e;
        e = due_q.pop_front();
        if (e.secs !== elapsed_seconds_o) begin
          errors++;
          $display("%0t: seconds expected %0d actual %0d", $time, e.secs, elapsed_seconds_o);
        end
        if (e.nsecs !== elapsed_nanoseconds_o) begin
          errors++;
          $display("%0t: nanoseconds expected %0d actual %0d", $time, e.nsecs,
                   elapsed_nanoseconds_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("tick_count_to_seconds_nanoseconds_tb: done, errors");
      $finish;
    end
  end

  initial begin
    reduce_ratio(ResetFreq);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_ratio();
    test_freq_extremes();
    test_full_pause();
    test_random_phase(32'd1, 200);
    test_random_phase(32'hFFFF_FFFF, 200);
    test_random_phase(32'd1000000000, 150);
    test_random_phase(32'd0, 100);
    repeat (6) test_random_phase($urandom_range(1, 32'hFFFF_FFFF), 120);
    test_random_phase($urandom_range(1, 100000), 120);
    drain();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d beats, checked %0d results, wrote the frequency %0d times.",
             beats_sent, beats_seen, freq_writes);
    $display("Covered default, extreme, ignored zero and random frequencies.");
    if (errors == 0 && due_q.size() == 0) begin
      $display("tick_count_to_seconds_nanoseconds_tb: done, clean");
    end else begin
      $display("tick_count_to_seconds_nanoseconds_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: tick_count_to_seconds_nanoseconds.f
design/tcsn_pkg.sv
design/tcsn_cell.sv
design/tcsn_div_chain.sv
design/tcsn_ratio.sv
design/tick_count_to_seconds_nanoseconds.sv
tb/tick_count_to_seconds_nanoseconds_tb.sv
